// ===== hdl/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and constants for the sorted sleep timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int TASK_ID_BITS = 8;
    localparam int TIME_BITS    = 64;
    localparam int STATUS_BITS  = 3;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_BITS = ((TASK_ID_BITS + 2 * TIME_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((TASK_ID_BITS + STATUS_BITS + 7) / 8) * 8;

    // result status codes
    localparam logic [STATUS_BITS-1:0] STATUS_QUEUED = 3'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_DUE    = 3'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL   = 3'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_WOKEN  = 3'd3;
    localparam logic [STATUS_BITS-1:0] STATUS_NONE   = 3'd4;

    // tuser function codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    // one queue slot
    typedef struct packed {
        logic                    valid;
        logic [TIME_BITS-1:0]    wake;
        logic [TASK_ID_BITS-1:0] task_id;
    } slot_t;

    // command broadcast along the cell row
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_SHIFT
    } cell_cmd_t;

endpackage

// ===== hdl/stq_cell.sv =====
// ----------------------------------------------------------------------------
// stq_cell
// One slot of the sorted queue: compares its wake time with the broadcast key
// and holds, takes the new entry, or takes a neighbour's slot.
// ----------------------------------------------------------------------------
module stq_cell
    import stq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_cmd_t            cmd,
    input  logic [TIME_BITS-1:0] key,
    input  slot_t                new_slot,
    input  slot_t                left_slot,
    input  logic                 left_le,
    input  slot_t                right_slot,
    output slot_t                slot,
    output logic                 le
);

    slot_t slot_reg;
    slot_t slot_next;

    // valid entry whose wake time is at or before the key
    assign le   = slot_reg.valid && (slot_reg.wake <= key);
    assign slot = slot_reg;

    always_comb
    begin
        slot_next = slot_reg;
        unique case (cmd)
            CMD_INSERT:
            begin
                if (!le)
                begin
                    // if the left neighbour stays put, the new entry lands here; else take the left slot
                    slot_next = left_le ? new_slot : left_slot;
                end
            end
            CMD_SHIFT:
            begin
                slot_next = right_slot;
            end
            default:
            begin
                slot_next = slot_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

endmodule

// ===== hdl/sleep_timer_queue_top.sv =====
// ----------------------------------------------------------------------------
// sleep_timer_queue_top
// Bounded queue of sleeping tasks, sorted by absolute wake time, built as a
// row of compare-and-shift cells.
// ----------------------------------------------------------------------------
//
// Channel  | Dir | Carries
// ---------+-----+-----------------------------------------------------------
// s_axis   | in  | tuser: func; tdata: task_id, wake, now
// m_axis   | out | tdata: woken_task, status; tlast: last
//
// Operation: on an insert the cell row finds its place and shifts in
// parallel. A tick checks the head, then pops one woken task per cycle
// while the output is free; the head cell goes out, the row shifts left.
// Reset clears the state machine, the output valid and every cell valid bit.
// A new transaction is taken only in idle and while the output register is
// empty or being drained; a stalled master side holds the pop sequence.
// ----------------------------------------------------------------------------
module sleep_timer_queue_top
    import stq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [S_TDATA_BITS-1:0] s_axis_tdata,  // task_id, wake, now
    input  logic                    s_axis_tuser,  // func
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [M_TDATA_BITS-1:0] m_axis_tdata,  // woken_task, status, zero pad
    output logic                    m_axis_tlast
);

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } state_t;

    state_t                  state_reg;
    logic [TIME_BITS-1:0]    now_reg;
    logic                    m_valid_reg;
    logic [TASK_ID_BITS-1:0] m_task_reg;
    logic [STATUS_BITS-1:0]  m_status_reg;
    logic                    m_last_reg;

    // input field unpacking
    logic [TASK_ID_BITS-1:0] in_task;
    logic [TIME_BITS-1:0]    in_wake;
    logic [TIME_BITS-1:0]    in_now;

    assign in_task = s_axis_tdata[TASK_ID_BITS-1:0];
    assign in_wake = s_axis_tdata[TASK_ID_BITS +: TIME_BITS];
    assign in_now  = s_axis_tdata[TASK_ID_BITS + TIME_BITS +: TIME_BITS];

    // handshake and control
    logic                    out_free;
    logic                    in_ready;
    logic                    in_accept;
    logic                    in_due;
    logic                    full;
    logic                    insert_go;
    logic                    pop_go;
    logic                    out_load;
    cell_cmd_t               cmd;
    logic [TIME_BITS-1:0]    key;
    slot_t                   new_slot;

    slot_t                   slots [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]  le;
    logic [QUEUE_DEPTH-1:0]  valid_vec;

    assign out_free  = !m_valid_reg || m_axis_tready;
    assign in_ready  = (state_reg == ST_IDLE) && out_free;
    assign in_accept = s_axis_tvalid && in_ready;
    assign in_due    = in_wake <= in_now;
    assign full      = slots[QUEUE_DEPTH-1].valid;
    assign insert_go = in_accept && (s_axis_tuser == FUNC_INSERT) && !in_due && !full;
    assign pop_go    = (state_reg == ST_POP) && out_free;
    // output register takes a new result this cycle
    assign out_load  = (in_accept && ((s_axis_tuser == FUNC_INSERT) || !le[0])) || pop_go;

    always_comb
    begin
        if (insert_go)
        begin
            cmd = CMD_INSERT;
        end
        else if (pop_go)
        begin
            cmd = CMD_SHIFT;
        end
        else
        begin
            cmd = CMD_HOLD;
        end
    end

    // one key broadcast to every cell comparator
    always_comb
    begin
        if (state_reg == ST_POP)
        begin
            key = now_reg;
        end
        else if (s_axis_tuser == FUNC_TICK)
        begin
            key = in_now;
        end
        else
        begin
            key = in_wake;
        end
    end

    assign new_slot.valid   = 1'b1;
    assign new_slot.wake    = in_wake;
    assign new_slot.task_id = in_task;

    // cell row: slot 0 is the head (earliest wake time)
    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++)
        begin : g_cell
            slot_t left_slot;
            slot_t right_slot;
            logic  left_le;

            if (g == 0)
            begin : g_head
                assign left_slot = '0;
                assign left_le   = 1'b1;
            end
            else
            begin : g_body
                assign left_slot = slots[g-1];
                assign left_le   = le[g-1];
            end

            if (g == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_slot = '0;
            end
            else
            begin : g_inner
                assign right_slot = slots[g+1];
            end

            stq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .key        (key),
                .new_slot   (new_slot),
                .left_slot  (left_slot),
                .left_le    (left_le),
                .right_slot (right_slot),
                .slot       (slots[g]),
                .le         (le[g])
            );

            assign valid_vec[g] = slots[g].valid;
        end
    endgenerate

    // state machine and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            now_reg      <= '0;
            m_task_reg   <= '0;
            m_status_reg <= STATUS_NONE;
            m_last_reg   <= 1'b0;
        end
        else
        begin
            if (m_axis_tready && !out_load)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (s_axis_tuser == FUNC_INSERT)
                        begin
                            m_valid_reg <= 1'b1;
                            m_task_reg  <= in_task;
                            m_last_reg  <= 1'b1;
                            priority if (in_due)
                            begin
                                m_status_reg <= STATUS_DUE;
                            end
                            else if (full)
                            begin
                                m_status_reg <= STATUS_FULL;
                            end
                            else
                            begin
                                m_status_reg <= STATUS_QUEUED;
                            end
                        end
                        else if (!le[0])
                        begin
                            // nothing due at the head
                            m_valid_reg  <= 1'b1;
                            m_task_reg   <= '0;
                            m_status_reg <= STATUS_NONE;
                            m_last_reg   <= 1'b1;
                        end
                        else
                        begin
                            now_reg   <= in_now;
                            state_reg <= ST_POP;
                        end
                    end
                end
                ST_POP:
                begin
                    if (out_free)
                    begin
                        m_valid_reg  <= 1'b1;
                        m_task_reg   <= slots[0].task_id;
                        m_status_reg <= STATUS_WOKEN;
                        m_last_reg   <= !le[1];
                        if (!le[1])
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {{(M_TDATA_BITS - TASK_ID_BITS - STATUS_BITS){1'b0}},
                            m_status_reg, m_task_reg};

`ifndef SYNTHESIS
    // while popping, the head cell always holds a due entry
    a_pop_head_due: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |-> le[0])
        else $error("pop state with no due entry at the head");

    // valid slots stay packed from the head
    a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec[QUEUE_DEPTH-1:1] & ~valid_vec[QUEUE_DEPTH-2:0]) == '0)
        else $error("gap in the valid slots");

    // an insert is never pushed into a full row
    a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_INSERT) |-> !valid_vec[QUEUE_DEPTH-1])
        else $error("insert issued into a full queue");

    // a successful insert adds exactly one entry
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_INSERT) |=>
            ($countones(valid_vec) == $countones($past(valid_vec)) + 1))
        else $error("insert did not grow the queue by one");
`endif

endmodule
